@@ src/snfs_pkg.sv @@
package snfs_pkg;

	localparam int unsigned PAGE_BYTES_DEF       = 256;
	localparam int unsigned ERASE_UNIT_BYTES_DEF = 65536;
	localparam int unsigned MAX_RES              = 8;
	localparam int unsigned QUEUE_DEPTH          = 4;

	typedef enum logic [2:0] {
		REQ_READ    = 3'd0,
		REQ_WSTART  = 3'd1,
		REQ_SECTOR  = 3'd2,
		REQ_CHIP    = 3'd3,
		REQ_WBYTE   = 3'd4,
		REQ_REPLY   = 3'd5,
		REQ_BUSYQ   = 3'd6,
		REQ_INVALID = 3'd7
	} req_e;

	typedef enum logic [2:0] {
		K_SEND    = 3'd0,
		K_RELEASE = 3'd1,
		K_RDATA   = 3'd2,
		K_BUSY    = 3'd3,
		K_DONE    = 3'd4
	} kind_e;

	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_RDSR  = 8'h05;
	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_PP    = 8'h02;
	localparam logic [7:0] CMD_SE    = 8'hD8;
	localparam logic [7:0] CMD_CE    = 8'hC7;
	localparam logic [7:0] DUMMY     = 8'hFF;
	localparam logic [7:0] WIP_MASK  = 8'h01;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [23:0] address;
		logic [15:0] length;
		logic [7:0]  data_byte;
		logic [7:0]  reply_byte;
		logic        wait_for_done;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] spi_byte;
		logic       needs_reply;
		logic [7:0] host_data;
		logic       last;
	} out_item_t;

	// Classified request as handed from the front part to the back part.
	typedef struct packed {
		req_e        req;
		logic [23:0] address;
		logic [15:0] length;
		logic [7:0]  data;
		logic        wait_for_done;
	} cmd_t;

endpackage

@@ src/spi_nor_flash_sequencer.sv @@
// Serial NOR flash command sequencer. Each request item is queued by a four-entry front
// queue and expanded by the back part into up to eight result items (bytes to send,
// chip-select releases, read data, busy status and done), delivered one per cycle while
// out_ready is high; the next request is expanded in the same cycle as the last item of
// the previous one is taken. Bytes marked needs_reply must be answered with a reply
// request carrying the byte read.
module spi_nor_flash_sequencer #(
	parameter int unsigned PAGE_BYTES       = snfs_pkg::PAGE_BYTES_DEF,
	parameter int unsigned ERASE_UNIT_BYTES = snfs_pkg::ERASE_UNIT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  snfs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output snfs_pkg::out_item_t out_item
);
	import snfs_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	snfs_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.cmd_valid, .cmd_ready, .cmd
	);

	snfs_back #(
		.PAGE_BYTES(PAGE_BYTES), .ERASE_UNIT_BYTES(ERASE_UNIT_BYTES)
	) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .out_item
	);

endmodule

@@ src/snfs_front.sv @@
module snfs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  snfs_pkg::in_item_t in_item,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output snfs_pkg::cmd_t    cmd
);
	import snfs_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;
	logic           push, pop;
	cmd_t           cl;

	always_comb begin
		cl.req           = req_e'(in_item.req_type);
		cl.address       = in_item.address;
		cl.length        = in_item.length;
		cl.data          = (in_item.req_type == REQ_REPLY) ? in_item.reply_byte
			: in_item.data_byte;
		cl.wait_for_done = in_item.wait_for_done;
	end

	assign in_ready  = (cnt_q != (PW+1)'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == (PW+1)'(QUEUE_DEPTH) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count");
`endif

endmodule

@@ src/snfs_back.sv @@
module snfs_back #(
	parameter int unsigned PAGE_BYTES       = snfs_pkg::PAGE_BYTES_DEF,
	parameter int unsigned ERASE_UNIT_BYTES = snfs_pkg::ERASE_UNIT_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  snfs_pkg::cmd_t     cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output snfs_pkg::out_item_t out_item
);
	import snfs_pkg::*;

	localparam int unsigned PGB = $clog2(PAGE_BYTES);
	localparam int unsigned EUB = $clog2(ERASE_UNIT_BYTES);
	localparam int unsigned RW  = $clog2(MAX_RES + 1);

	typedef enum logic [2:0] {
		PH_IDLE, PH_PREP_POLL, PH_DATA, PH_END_POLL, PH_READ, PH_BUSYQ
	} phase_t;

	localparam logic [1:0] PP_SECTOR = 2'd0;
	localparam logic [1:0] PP_CHIP   = 2'd1;
	localparam logic [1:0] PP_PROG   = 2'd2;
	localparam logic [1:0] PP_UNIT   = 2'd3;
	localparam logic [1:0] EP_DONE   = 2'd0;
	localparam logic [1:0] EP_NEXT   = 2'd1;
	localparam logic [1:0] EP_THEN   = 2'd2;

	phase_t      phase_q, ph_n;
	logic [23:0] addr_q, addr_n;
	logic [15:0] left_q, left_n;
	logic [1:0]  purp_q, purp_n;
	logic        async_q, async_n;

	out_item_t   buf_q [MAX_RES];
	out_item_t   res   [MAX_RES];
	logic [RW-1:0] cnt_q, pos_q, nres;

	logic busy;
	logic take;

	assign busy      = (cnt_q != '0);
	assign cmd_ready = !busy || (out_ready && pos_q == cnt_q - 1'b1);
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = busy;
	always_comb begin
		out_item      = buf_q[pos_q[RW-2:0]];
		out_item.last = (pos_q == cnt_q - 1'b1);
	end

	// Builds the list of result items for one request; at most eight per request.
	always_comb begin
		logic [RW-1:0] n;
		logic [23:0]   a1;
		logic [15:0]   l1;
		logic          unit0;
		n       = '0;
		ph_n    = phase_q;
		addr_n  = addr_q;
		left_n  = left_q;
		purp_n  = purp_q;
		async_n = async_q;
		a1      = '0;
		l1      = '0;
		unit0   = (addr_q[EUB-1:0] == '0);
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end
		unique case (phase_q)
			PH_IDLE: begin
				unique case (cmd.req)
					REQ_READ: begin
						addr_n = cmd.address;
						left_n = cmd.length;
						res[0] = '{K_SEND, CMD_READ, 1'b0, 8'h00, 1'b0};
						res[1] = '{K_SEND, cmd.address[23:16], 1'b0, 8'h00, 1'b0};
						res[2] = '{K_SEND, cmd.address[15:8], 1'b0, 8'h00, 1'b0};
						res[3] = '{K_SEND, cmd.address[7:0], 1'b0, 8'h00, 1'b0};
						if (cmd.length == '0) begin
							res[4] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							res[5] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
							n = RW'(6);
						end else begin
							res[4] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
							n = RW'(5);
							ph_n = PH_READ;
						end
					end
					REQ_WSTART: begin
						addr_n  = cmd.address;
						left_n  = cmd.length;
						async_n = 1'b0;
						if (cmd.length == '0) begin
							res[0] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
							n = RW'(1);
						end else begin
							res[0] = '{K_SEND, CMD_WREN, 1'b0, 8'h00, 1'b0};
							res[1] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
							res[3] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
							n = RW'(4);
							ph_n = PH_PREP_POLL;
							purp_n = (cmd.address[EUB-1:0] == '0) ? PP_UNIT : PP_PROG;
						end
					end
					REQ_SECTOR, REQ_CHIP: begin
						addr_n  = cmd.address;
						async_n = !cmd.wait_for_done;
						res[0] = '{K_SEND, CMD_WREN, 1'b0, 8'h00, 1'b0};
						res[1] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
						res[2] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
						res[3] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
						n = RW'(4);
						ph_n = PH_PREP_POLL;
						purp_n = (cmd.req == REQ_SECTOR) ? PP_SECTOR : PP_CHIP;
					end
					REQ_BUSYQ: begin
						res[0] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
						res[1] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
						n = RW'(2);
						ph_n = PH_BUSYQ;
					end
					default: begin
					end
				endcase
			end
			PH_DATA: begin
				if (cmd.req == REQ_WBYTE) begin
					a1 = addr_q + 24'd1;
					l1 = left_q - 16'd1;
					addr_n = a1;
					left_n = l1;
					res[0] = '{K_SEND, cmd.data, 1'b0, 8'h00, 1'b0};
					n = RW'(1);
					if (l1 == '0 || a1[PGB-1:0] == '0) begin
						res[1] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
						res[2] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
						res[3] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
						n = RW'(4);
						ph_n = PH_END_POLL;
						purp_n = EP_NEXT;
					end
				end
			end
			default: begin
				if (cmd.req == REQ_REPLY) begin
					if ((phase_q == PH_PREP_POLL || phase_q == PH_END_POLL)
						&& cmd.data[0]) begin
						res[0] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
						n = RW'(1);
					end else if (phase_q == PH_PREP_POLL) begin
						res[0] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
						if (purp_q == PP_PROG) begin
							res[1] = '{K_SEND, CMD_PP, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_SEND, addr_q[23:16], 1'b0, 8'h00, 1'b0};
							res[3] = '{K_SEND, addr_q[15:8], 1'b0, 8'h00, 1'b0};
							res[4] = '{K_SEND, addr_q[7:0], 1'b0, 8'h00, 1'b0};
							n = RW'(5);
							ph_n = PH_DATA;
						end else if (purp_q == PP_CHIP) begin
							res[1] = '{K_SEND, CMD_CE, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							if (async_q) begin
								res[3] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
								n = RW'(4);
								ph_n = PH_IDLE;
							end else begin
								res[3] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
								res[4] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
								n = RW'(5);
								ph_n = PH_END_POLL;
								purp_n = EP_DONE;
							end
						end else begin
							res[1] = '{K_SEND, CMD_SE, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_SEND, addr_q[23:16], 1'b0, 8'h00, 1'b0};
							res[3] = '{K_SEND, addr_q[15:8], 1'b0, 8'h00, 1'b0};
							res[4] = '{K_SEND, addr_q[7:0], 1'b0, 8'h00, 1'b0};
							res[5] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							if (purp_q == PP_SECTOR && async_q) begin
								res[6] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
								n = RW'(7);
								ph_n = PH_IDLE;
							end else begin
								res[6] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
								res[7] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
								n = RW'(8);
								ph_n = PH_END_POLL;
								purp_n = (purp_q == PP_UNIT) ? EP_THEN : EP_DONE;
							end
						end
					end else if (phase_q == PH_END_POLL) begin
						res[0] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
						if (purp_q == EP_THEN || (purp_q == EP_NEXT && left_q != '0)) begin
							res[1] = '{K_SEND, CMD_WREN, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							res[3] = '{K_SEND, CMD_RDSR, 1'b0, 8'h00, 1'b0};
							res[4] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
							n = RW'(5);
							ph_n = PH_PREP_POLL;
							purp_n = (purp_q == EP_NEXT && unit0) ? PP_UNIT : PP_PROG;
						end else begin
							res[1] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
							n = RW'(2);
							ph_n = PH_IDLE;
						end
					end else if (phase_q == PH_READ) begin
						l1 = left_q - 16'd1;
						left_n = l1;
						res[0] = '{K_RDATA, 8'h00, 1'b0, cmd.data, 1'b0};
						if (l1 == '0) begin
							res[1] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
							res[2] = '{K_DONE, 8'h00, 1'b0, 8'h00, 1'b0};
							n = RW'(3);
							ph_n = PH_IDLE;
						end else begin
							res[1] = '{K_SEND, DUMMY, 1'b1, 8'h00, 1'b0};
							n = RW'(2);
						end
					end else begin
						res[0] = '{K_RELEASE, 8'h00, 1'b0, 8'h00, 1'b0};
						res[1] = '{K_BUSY, 8'h00, 1'b0, 8'h00 | (cmd.data & WIP_MASK), 1'b0};
						n = RW'(2);
						ph_n = PH_IDLE;
					end
				end
			end
		endcase
		nres = n;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			left_q  <= '0;
			purp_q  <= '0;
			async_q <= 1'b0;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			if (take) begin
				phase_q <= ph_n;
				addr_q  <= addr_n;
				left_q  <= left_n;
				purp_q  <= purp_n;
				async_q <= async_n;
				cnt_q   <= nres;
				pos_q   <= '0;
			end else if (busy && out_ready) begin
				if (pos_q == cnt_q - 1'b1) begin
					cnt_q <= '0;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

`ifndef SYNTH
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> pos_q < cnt_q) else $error("position beyond count");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RW'(MAX_RES)) else $error("too many results");
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		take && nres == '0 |=> !busy) else $error("empty request left items");
`endif

endmodule
